[rtl/tdts_pkg.sv]
// Shared types, field widths, codes and reset constants of the tone sequencer.
`default_nettype none

package tdts_pkg;

  // Default depth of the note memory
  localparam int unsigned NoteDepth = 64;

  // Field widths
  localparam int unsigned OpW    = 3;
  localparam int unsigned LdIdxW = 6;
  localparam int unsigned NoteW  = 16;
  localparam int unsigned DurW   = 16;
  localparam int unsigned ModeW  = 2;
  localparam int unsigned LenW   = 7;
  localparam int unsigned StepW  = 8;
  localparam int unsigned ElapW  = 17;
  localparam int unsigned EntryW = NoteW + DurW;

  // Stream widths, whole bytes
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 24;
  localparam int unsigned CfgDataW = 8;

  // Register reset values
  localparam logic [LenW-1:0]  TuneLenRst  = 7'd1;
  localparam logic [StepW-1:0] TickStepRst = 8'd10;
  localparam logic [ElapW-1:0] ElapMax     = {ElapW{1'b1}};

  typedef enum logic [OpW-1:0] {
    OP_TICK    = 3'd0,
    OP_LOAD    = 3'd1,
    OP_START   = 3'd2,
    OP_STOP    = 3'd3,
    OP_PAUSE   = 3'd4,
    OP_UNPAUSE = 3'd5
  } op_e;

  typedef enum logic [ModeW-1:0] {
    MODE_STOPPED = 2'd0,
    MODE_PLAYING = 2'd1,
    MODE_PAUSED  = 2'd2
  } mode_e;

  // Configuration register indexes
  typedef enum logic {
    CFG_TUNE_LEN  = 1'b0,
    CFG_TICK_STEP = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [OpW-1:0]    op;
    logic [LdIdxW-1:0] load_index;
    logic [NoteW-1:0]  load_note;
    logic [DurW-1:0]   load_duration;
  } item_t;

  typedef struct packed {
    logic             drive_valid;
    logic [NoteW-1:0] drive_note;
    mode_e            player_mode;
  } result_t;

endpackage

`default_nettype wire

[rtl/tick_driven_tone_sequencer_unit.sv]
// Tone sequencer top level: stream handshake, config registers, note memory and player.
//
// Usage:
//   Slave stream s_axis carries one command per transfer: tuser holds the op
//   (tick, load, start, stop, pause, unpause); tdata holds the load index,
//   tone code and duration. Master stream m_axis returns exactly one result
//   per command: tuser flags a new tone for the buzzer, tdata holds the tone
//   code and the player mode after the command.
//   Config port: cfg_we_i writes register cfg_idx_i (0 tune length,
//   1 tick step) from cfg_data_i; write only while no command is in flight.
// Pipeline and throughput:
//   A command is taken into the input register, the note memory read for it
//   is issued in that same edge, and its result is then registered in the
//   result register; one command per cycle is sustained while m_axis_tready
//   is high. The rate is set by the single state update per cycle in the player.
// Reset: player stopped, position 0, tune length 1, tick step 10; note memory
//   contents are undefined until loaded.
// Stall: the output register holds its result while m_axis_tready is low;
//   the input register takes one more command, then s_axis_tready drops.
`default_nettype none

module tick_driven_tone_sequencer_unit #(
  parameter int unsigned NOTE_DEPTH = tdts_pkg::NoteDepth
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // Slave stream
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // [5:0] load_index, [21:6] load_note, [37:22] load_duration, [39:38] zero
  input  wire logic [tdts_pkg::InDataW-1:0]     s_axis_tdata,
  // [2:0] op
  input  wire logic [tdts_pkg::OpW-1:0]         s_axis_tuser,
  // Master stream
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // [15:0] drive_note, [17:16] player_mode, [23:18] zero
  output logic      [tdts_pkg::OutDataW-1:0]    m_axis_tdata,
  // [0] drive_valid
  output logic      [0:0]                       m_axis_tuser,
  // Config write port
  input  wire logic                             cfg_we_i,
  input  wire logic                             cfg_idx_i,
  input  wire logic [tdts_pkg::CfgDataW-1:0]    cfg_data_i
);

  localparam int unsigned IdxW = $clog2(NOTE_DEPTH);

  logic                              in_vld_q, out_vld_q, adv, s_xfer;
  tdts_pkg::item_t                   item_q, item_in;
  tdts_pkg::result_t                 res, res_q;
  logic [tdts_pkg::LenW-1:0]         tune_len_q;
  logic [tdts_pkg::StepW-1:0]        tick_step_q;
  logic [IdxW-1:0]                   rd_pos, rd_prev, wr_addr;
  logic                              wr_en;
  logic [tdts_pkg::EntryW-1:0]       wr_data, rd_cur, rd_prv;

  // Handshake
  assign adv           = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || adv;
  assign s_xfer        = s_axis_tvalid && s_axis_tready;

  // Input unpack
  assign item_in.op            = s_axis_tuser;
  assign item_in.load_index    = s_axis_tdata[5:0];
  assign item_in.load_note     = s_axis_tdata[21:6];
  assign item_in.load_duration = s_axis_tdata[37:22];

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_xfer) begin
      in_vld_q <= 1'b1;
    end else if (adv) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      item_q <= item_in;
    end
  end

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tune_len_q  <= tdts_pkg::TuneLenRst;
      tick_step_q <= tdts_pkg::TickStepRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tdts_pkg::CFG_TUNE_LEN:  tune_len_q  <= cfg_data_i[tdts_pkg::LenW-1:0];
        tdts_pkg::CFG_TICK_STEP: tick_step_q <= cfg_data_i[tdts_pkg::StepW-1:0];
        default: ;
      endcase
    end
  end

  tdts_note_mem #(
    .NOTE_DEPTH (NOTE_DEPTH)
  ) u_mem (
    .clk_i       (clk_i),
    .wr_en_i     (wr_en),
    .wr_addr_i   (wr_addr),
    .wr_data_i   (wr_data),
    .rd_en_i     (s_xfer),
    .rd_addr_a_i (rd_pos),
    .rd_addr_b_i (rd_prev),
    .rd_data_a_o (rd_cur),
    .rd_data_b_o (rd_prv)
  );

  tdts_ctrl #(
    .NOTE_DEPTH (NOTE_DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .item_i      (item_q),
    .tune_len_i  (tune_len_q),
    .tick_step_i (tick_step_q),
    .cur_note_i  (rd_cur[tdts_pkg::NoteW-1:0]),
    .prev_dur_i  (rd_prv[tdts_pkg::EntryW-1:tdts_pkg::NoteW]),
    .res_o       (res),
    .rd_pos_o    (rd_pos),
    .rd_prev_o   (rd_prev),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res;
    end
  end

  // Output pack
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = res_q.drive_valid;
  assign m_axis_tdata  = {{(tdts_pkg::OutDataW - tdts_pkg::NoteW - tdts_pkg::ModeW){1'b0}},
                          res_q.player_mode, res_q.drive_note};

  // Checks
  a_silent_without_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[tdts_pkg::NoteW-1:0] == '0))
    else $error("note field nonzero without a new tone");

  a_ready_only_blocked_by_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_vld_q && out_vld_q && !m_axis_tready))
    else $error("input blocked without a held result");

  a_adv_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_vld_q)
    else $error("processed command produced no result");

  a_held_item_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !adv) |=> (in_vld_q && $stable(item_q)))
    else $error("waiting command lost or changed");

endmodule

`default_nettype wire

[rtl/tdts_note_mem.sv]
// Note memory: one write port, two registered read ports with write bypass.
`default_nettype none

module tdts_note_mem #(
  parameter int unsigned NOTE_DEPTH = tdts_pkg::NoteDepth,
  localparam int unsigned IdxW = $clog2(NOTE_DEPTH)
) (
  input  wire logic                        clk_i,
  input  wire logic                        wr_en_i,
  input  wire logic [IdxW-1:0]             wr_addr_i,
  input  wire logic [tdts_pkg::EntryW-1:0] wr_data_i,
  input  wire logic                        rd_en_i,
  input  wire logic [IdxW-1:0]             rd_addr_a_i,
  input  wire logic [IdxW-1:0]             rd_addr_b_i,
  output logic      [tdts_pkg::EntryW-1:0] rd_data_a_o,
  output logic      [tdts_pkg::EntryW-1:0] rd_data_b_o
);

  logic [tdts_pkg::EntryW-1:0] mem [NOTE_DEPTH];
  logic [tdts_pkg::EntryW-1:0] rd_a_q, rd_b_q, wr_fwd_q;
  logic                        byp_a_q, byp_b_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Read ports; a same-edge write to the read address is forwarded
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_a_q   <= mem[rd_addr_a_i];
      rd_b_q   <= mem[rd_addr_b_i];
      byp_a_q  <= wr_en_i && (wr_addr_i == rd_addr_a_i);
      byp_b_q  <= wr_en_i && (wr_addr_i == rd_addr_b_i);
      wr_fwd_q <= wr_data_i;
    end
  end

  assign rd_data_a_o = byp_a_q ? wr_fwd_q : rd_a_q;
  assign rd_data_b_o = byp_b_q ? wr_fwd_q : rd_b_q;

endmodule

`default_nettype wire

[rtl/tdts_ctrl.sv]
// Player state: mode machine, play position, note timer and result build.
`default_nettype none

module tdts_ctrl #(
  parameter int unsigned NOTE_DEPTH = tdts_pkg::NoteDepth,
  localparam int unsigned IdxW = $clog2(NOTE_DEPTH)
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         adv_i,
  input  wire tdts_pkg::item_t              item_i,
  input  wire logic [tdts_pkg::LenW-1:0]    tune_len_i,
  input  wire logic [tdts_pkg::StepW-1:0]   tick_step_i,
  input  wire logic [tdts_pkg::NoteW-1:0]   cur_note_i,
  input  wire logic [tdts_pkg::DurW-1:0]    prev_dur_i,
  output tdts_pkg::result_t                 res_o,
  output logic      [IdxW-1:0]              rd_pos_o,
  output logic      [IdxW-1:0]              rd_prev_o,
  output logic                              wr_en_o,
  output logic      [IdxW-1:0]              wr_addr_o,
  output logic      [tdts_pkg::EntryW-1:0]  wr_data_o
);

  // Wide enough for the tune length register and for NOTE_DEPTH itself
  localparam int unsigned CntW = (IdxW + 1 > tdts_pkg::LenW) ? IdxW + 1 : tdts_pkg::LenW;
  localparam logic [CntW-1:0] DepthC = CntW'(NOTE_DEPTH);

  tdts_pkg::mode_e                mode_q, mode_d;
  logic [IdxW-1:0]                pos_q, pos_d;
  logic                           act_q, act_d;
  logic [tdts_pkg::ElapW-1:0]     elap_q, elap_d;

  logic [CntW-1:0]                len, len_raw, pos_inc;
  logic [tdts_pkg::ElapW-1:0]     elap_base;
  logic [tdts_pkg::ElapW:0]       elap_sum;
  logic                           expired, playing, is_tick, is_pause;

  // Effective tune length, clamped to 1..NOTE_DEPTH
  always_comb begin
    len_raw = CntW'(tune_len_i);
    if (len_raw == '0) begin
      len = CntW'(1);
    end else if (len_raw > DepthC) begin
      len = DepthC;
    end else begin
      len = len_raw;
    end
  end

  assign playing  = (mode_q == tdts_pkg::MODE_PLAYING);
  assign is_tick  = (item_i.op == tdts_pkg::OP_TICK);
  assign is_pause = (item_i.op == tdts_pkg::OP_PAUSE);
  assign pos_inc  = CntW'(pos_q) + CntW'(1);
  assign expired  = elap_q > tdts_pkg::ElapW'(prev_dur_i);
  assign elap_base = expired ? '0 : elap_q;
  assign elap_sum  = {1'b0, elap_base} + (tdts_pkg::ElapW + 1)'(tick_step_i);

  // Mode next state
  always_comb begin
    mode_d = mode_q;
    if (adv_i) begin
      case (item_i.op)
        tdts_pkg::OP_START: begin
          if (mode_q == tdts_pkg::MODE_STOPPED) mode_d = tdts_pkg::MODE_PLAYING;
        end
        tdts_pkg::OP_STOP: begin
          if (playing) mode_d = tdts_pkg::MODE_STOPPED;
        end
        tdts_pkg::OP_PAUSE: begin
          if (playing) mode_d = tdts_pkg::MODE_PAUSED;
        end
        tdts_pkg::OP_UNPAUSE: begin
          if (mode_q == tdts_pkg::MODE_PAUSED) mode_d = tdts_pkg::MODE_PLAYING;
        end
        default: ;
      endcase
    end
  end

  // Position and note timer
  always_comb begin
    pos_d  = pos_q;
    act_d  = act_q;
    elap_d = elap_q;
    if (adv_i) begin
      case (item_i.op)
        tdts_pkg::OP_TICK: begin
          if (playing) begin
            if (!act_q) begin
              pos_d = (pos_inc >= len) ? '0 : pos_inc[IdxW-1:0];
              act_d = 1'b1;
            end else begin
              if (expired) act_d = 1'b0;
              elap_d = elap_sum[tdts_pkg::ElapW] ? tdts_pkg::ElapMax
                                                  : elap_sum[tdts_pkg::ElapW-1:0];
            end
          end
        end
        tdts_pkg::OP_START: begin
          if (mode_q == tdts_pkg::MODE_STOPPED) begin
            act_d  = 1'b0;
            elap_d = '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Outputs: result, read addresses for the next item, memory write
  always_comb begin
    res_o.drive_valid = playing && ((is_tick && !act_q) || is_pause);
    res_o.drive_note  = (playing && is_tick && !act_q) ? cur_note_i : '0;
    res_o.player_mode = mode_d;

    rd_pos_o  = pos_d;
    rd_prev_o = (pos_d == '0) ? IdxW'(len - CntW'(1)) : pos_d - IdxW'(1);

    wr_en_o   = adv_i && (item_i.op == tdts_pkg::OP_LOAD) &&
                ((CntW + tdts_pkg::LdIdxW)'(item_i.load_index) <
                 (CntW + tdts_pkg::LdIdxW)'(NOTE_DEPTH));
    wr_addr_o = IdxW'(item_i.load_index);
    wr_data_o = {item_i.load_duration, item_i.load_note};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= tdts_pkg::MODE_STOPPED;
      pos_q  <= '0;
      act_q  <= 1'b0;
      elap_q <= '0;
    end else begin
      mode_q <= mode_d;
      pos_q  <= pos_d;
      act_q  <= act_d;
      elap_q <= elap_d;
    end
  end

endmodule

`default_nettype wire

[tb/tb.sv]
// Self-checking stream testbench for the tick-driven tone sequencer.
`timescale 1ns / 100ps

module tb;

  // Opcodes outside the defined set; the block must ignore them
  localparam logic [tdts_pkg::OpW-1:0] OP_RSVD_A = 3'd6;
  localparam logic [tdts_pkg::OpW-1:0] OP_RSVD_B = 3'd7;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  // [5:0] load_index, [21:6] load_note, [37:22] load_duration
  logic [tdts_pkg::InDataW-1:0]  s_axis_tdata;
  logic [tdts_pkg::OpW-1:0]      s_axis_tuser;   // [2:0] op
  logic                          m_axis_tvalid;
  logic                          m_axis_tready;
  // [15:0] drive_note, [17:16] player_mode
  logic [tdts_pkg::OutDataW-1:0] m_axis_tdata;
  logic [0:0]                    m_axis_tuser;   // [0] drive_valid
  logic                          cfg_we_i;
  logic                          cfg_idx_i;
  logic [tdts_pkg::CfgDataW-1:0] cfg_data_i;

  // Shadow copy of the player and its registers
  tdts_pkg::mode_e               plr_mode;
  logic [tdts_pkg::LdIdxW-1:0]   plr_pos;
  bit                            plr_active;
  logic [tdts_pkg::ElapW-1:0]    plr_elapsed;
  logic [tdts_pkg::EntryW-1:0]   note_mem [tdts_pkg::NoteDepth];
  logic [tdts_pkg::LenW-1:0]     tune_len;
  logic [tdts_pkg::StepW-1:0]    tick_step;

  tdts_pkg::result_t             tone_results_due [$];
  int                            fail_cnt;
  bit                            send_gaps;
  bit                            recv_gaps;
  bit                            hold_req;

  tick_driven_tone_sequencer_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Advance the shadow player by one command and return the tone result it yields
  function automatic tdts_pkg::result_t next_tone_result(
      input logic [tdts_pkg::OpW-1:0]    op,
      input logic [tdts_pkg::LdIdxW-1:0] idx,
      input logic [tdts_pkg::NoteW-1:0]  note,
      input logic [tdts_pkg::DurW-1:0]   dur);
    tdts_pkg::result_t           r;
    logic [tdts_pkg::LenW-1:0]   len;
    logic [tdts_pkg::LenW-1:0]   nxt;
    logic [tdts_pkg::LdIdxW-1:0] prev;
    logic [tdts_pkg::ElapW:0]    sum;
    r.drive_valid = 1'b0;
    r.drive_note  = '0;
    // Clamp the tune length into 1..depth
    len = (tune_len == '0) ? tdts_pkg::LenW'(1) :
          (tune_len > tdts_pkg::LenW'(tdts_pkg::NoteDepth)) ?
          tdts_pkg::LenW'(tdts_pkg::NoteDepth) : tune_len;
    case (op)
      tdts_pkg::OP_TICK: begin
        if (plr_mode == tdts_pkg::MODE_PLAYING) begin
          if (!plr_active) begin
            r.drive_valid = 1'b1;
            r.drive_note  = note_mem[plr_pos][tdts_pkg::NoteW-1:0];
            nxt = {1'b0, plr_pos} + tdts_pkg::LenW'(1);
            plr_pos = (nxt >= len) ? '0 : nxt[tdts_pkg::LdIdxW-1:0];
            plr_active = 1'b1;
          end else begin
            // Duration of the note last sent, one behind the position
            prev = (plr_pos == '0) ? tdts_pkg::LdIdxW'(len - tdts_pkg::LenW'(1))
                                   : plr_pos - 1'b1;
            if (plr_elapsed >
                tdts_pkg::ElapW'(note_mem[prev][tdts_pkg::EntryW-1:tdts_pkg::NoteW])) begin
              plr_active  = 1'b0;
              plr_elapsed = '0;
            end
            sum = {1'b0, plr_elapsed} + (tdts_pkg::ElapW + 1)'(tick_step);
            plr_elapsed = (sum > {1'b0, tdts_pkg::ElapMax}) ? tdts_pkg::ElapMax
                                                             : sum[tdts_pkg::ElapW-1:0];
          end
        end
      end
      tdts_pkg::OP_LOAD: note_mem[idx] = {dur, note};
      tdts_pkg::OP_START: begin
        if (plr_mode == tdts_pkg::MODE_STOPPED) begin
          plr_mode    = tdts_pkg::MODE_PLAYING;
          plr_elapsed = '0;
          plr_active  = 1'b0;
        end
      end
      tdts_pkg::OP_STOP: begin
        if (plr_mode == tdts_pkg::MODE_PLAYING) plr_mode = tdts_pkg::MODE_STOPPED;
      end
      tdts_pkg::OP_PAUSE: begin
        if (plr_mode == tdts_pkg::MODE_PLAYING) begin
          plr_mode      = tdts_pkg::MODE_PAUSED;
          r.drive_valid = 1'b1;
        end
      end
      tdts_pkg::OP_UNPAUSE: begin
        if (plr_mode == tdts_pkg::MODE_PAUSED) plr_mode = tdts_pkg::MODE_PLAYING;
      end
      default: ;
    endcase
    r.player_mode = plr_mode;
    return r;
  endfunction

  // Offer one command, wait for its transfer, then record the expected tone
  task automatic send_item(input logic [tdts_pkg::OpW-1:0]    op,
                           input logic [tdts_pkg::LdIdxW-1:0] idx,
                           input logic [tdts_pkg::NoteW-1:0]  note,
                           input logic [tdts_pkg::DurW-1:0]   dur);
    if (send_gaps && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, dur, note, idx};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    tone_results_due.push_back(next_tone_result(op, idx, note, dur));
  endtask

  // Random command, weighted toward ticks so tunes actually progress
  task automatic send_random_item();
    int unsigned                 pick;
    logic [tdts_pkg::OpW-1:0]    op;
    logic [tdts_pkg::DurW-1:0]   dur;
    pick = $urandom_range(0, 99);
    if (pick < 50)      op = tdts_pkg::OP_TICK;
    else if (pick < 62) op = tdts_pkg::OP_LOAD;
    else if (pick < 72) op = tdts_pkg::OP_START;
    else if (pick < 79) op = tdts_pkg::OP_STOP;
    else if (pick < 86) op = tdts_pkg::OP_PAUSE;
    else if (pick < 94) op = tdts_pkg::OP_UNPAUSE;
    else                op = $urandom_range(0, 1) ? OP_RSVD_A : OP_RSVD_B;
    // Mostly short notes, some full-range durations
    dur = ($urandom_range(0, 3) != 0) ? tdts_pkg::DurW'($urandom_range(0, 60))
                                      : tdts_pkg::DurW'($urandom);
    send_item(op, tdts_pkg::LdIdxW'($urandom), tdts_pkg::NoteW'($urandom), dur);
  endtask

  // Sender pause: stop offering until every expected tone is back
  task automatic wait_results_drained();
    s_axis_tvalid <= 1'b0;
    while (tone_results_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_cfg(input tdts_pkg::cfg_idx_e idx,
                           input logic [tdts_pkg::CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    if (idx == tdts_pkg::CFG_TUNE_LEN) tune_len = val[tdts_pkg::LenW-1:0];
    else tick_step = val;
  endtask

  // Every entry is written before any tick can read it
  task automatic test_fill_memory();
    for (int i = 0; i < tdts_pkg::NoteDepth; i++)
      send_item(tdts_pkg::OP_LOAD, tdts_pkg::LdIdxW'(i), tdts_pkg::NoteW'($urandom),
                tdts_pkg::DurW'($urandom_range(0, 40)));
  endtask

  // Control commands while stopped and undefined opcodes
  task automatic test_idle_commands();
    send_item(tdts_pkg::OP_TICK, '0, '0, '0);
    send_item(tdts_pkg::OP_STOP, '0, '0, '0);
    send_item(tdts_pkg::OP_PAUSE, '1, '1, '1);
    send_item(tdts_pkg::OP_UNPAUSE, '0, '0, '0);
    send_item(OP_RSVD_A, '1, '1, '1);
    send_item(OP_RSVD_B, '0, '0, '0);
  endtask

  // Start/stop/pause sequencing, note release, position kept across stop
  task automatic test_play_controls();
    send_item(tdts_pkg::OP_LOAD, '0, 16'hFFFF, 16'h0000);
    send_item(tdts_pkg::OP_LOAD, 6'd63, 16'h0000, 16'hFFFF);
    send_item(tdts_pkg::OP_START, '0, '0, '0);
    send_item(tdts_pkg::OP_START, '0, '0, '0);
    send_item(tdts_pkg::OP_TICK, '0, '0, '0);
    send_item(tdts_pkg::OP_TICK, '0, '0, '0);
    send_item(tdts_pkg::OP_TICK, '0, '0, '0);
    send_item(tdts_pkg::OP_TICK, '0, '0, '0);
    send_item(tdts_pkg::OP_PAUSE, '0, '0, '0);
    send_item(tdts_pkg::OP_STOP, '0, '0, '0);
    send_item(tdts_pkg::OP_TICK, '0, '0, '0);
    send_item(tdts_pkg::OP_PAUSE, '0, '0, '0);
    send_item(tdts_pkg::OP_UNPAUSE, '0, '0, '0);
    send_item(tdts_pkg::OP_UNPAUSE, '0, '0, '0);
    send_item(tdts_pkg::OP_TICK, '0, '0, '0);
    send_item(tdts_pkg::OP_STOP, '0, '0, '0);
    send_item(tdts_pkg::OP_START, '0, '0, '0);
    send_item(tdts_pkg::OP_LOAD, 6'd1, tdts_pkg::NoteW'($urandom),
              tdts_pkg::DurW'($urandom_range(0, 40)));
    send_item(tdts_pkg::OP_TICK, '0, '0, '0);
  endtask

  task automatic run_tune_phase(input logic [tdts_pkg::CfgDataW-1:0] len_val,
                                input logic [tdts_pkg::CfgDataW-1:0] step_val,
                                input int n_items);
    wait_results_drained();
    write_cfg(tdts_pkg::CFG_TUNE_LEN, len_val);
    write_cfg(tdts_pkg::CFG_TICK_STEP, step_val);
    repeat (n_items) send_random_item();
  endtask

  // Tune length zero, above depth, masked high bit; tick step extremes
  task automatic test_random_tunes();
    run_tune_phase(8'd0, 8'd255, 100);
    run_tune_phase(8'hFF, 8'd1, 100);
    run_tune_phase(8'd64, 8'd255, 100);
    run_tune_phase(8'h83, 8'd10, 100);
    run_tune_phase(8'd1, 8'd0, 30);
    repeat (3)
      run_tune_phase(tdts_pkg::CfgDataW'($urandom_range(1, 64)),
                     tdts_pkg::CfgDataW'($urandom_range(1, 255)), 110);
  endtask

  // Long receiver hold while the sender keeps offering back to back
  task automatic test_output_backpressure();
    send_gaps = 1'b0;
    hold_req  = 1'b1;
    repeat (20) send_random_item();
    send_gaps = 1'b1;
  endtask

  // Sender pauses mid-stream until all tones are back, then resumes
  task automatic test_sender_pause();
    repeat (10) send_random_item();
    wait_results_drained();
    repeat (10) send_random_item();
  endtask

  // Closing stretch with both sides running flat out
  task automatic test_full_rate();
    send_gaps = 1'b0;
    recv_gaps = 1'b0;
    run_tune_phase(tdts_pkg::CfgDataW'($urandom_range(1, 64)),
                   tdts_pkg::CfgDataW'($urandom_range(1, 255)), 110);
  endtask

  // Main sequence
  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= tdts_pkg::CFG_TUNE_LEN;
    cfg_data_i    <= '0;
    plr_mode    = tdts_pkg::MODE_STOPPED;
    plr_pos     = '0;
    plr_active  = 1'b0;
    plr_elapsed = '0;
    tune_len    = tdts_pkg::TuneLenRst;
    tick_step   = tdts_pkg::TickStepRst;
    fail_cnt    = 0;
    send_gaps   = 1'b1;
    recv_gaps   = 1'b1;
    hold_req    = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_fill_memory();
    test_idle_commands();
    test_play_controls();
    test_random_tunes();
    test_output_backpressure();
    test_sender_pause();
    test_full_rate();

    wait_results_drained();
    repeat (10) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Result side: random stalls, one long hold on request, field checks per transfer
  initial begin
    int                stall_left;
    tdts_pkg::result_t due_r;
    stall_left = 0;
    m_axis_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        if (tone_results_due.size() == 0) begin
          $display("%0t: unexpected result: tdata %h tuser %h", $time, m_axis_tdata,
                   m_axis_tuser);
          fail_cnt++;
        end else begin
          due_r = tone_results_due.pop_front();
          if (m_axis_tuser[0] !== due_r.drive_valid) begin
            $display("%0t: drive_valid mismatch: expected %b, actual %b", $time,
                     due_r.drive_valid, m_axis_tuser[0]);
            fail_cnt++;
          end
          if (m_axis_tdata[tdts_pkg::NoteW-1:0] !== due_r.drive_note) begin
            $display("%0t: drive_note mismatch: expected %h, actual %h", $time,
                     due_r.drive_note, m_axis_tdata[tdts_pkg::NoteW-1:0]);
            fail_cnt++;
          end
          if (m_axis_tdata[tdts_pkg::NoteW+tdts_pkg::ModeW-1:tdts_pkg::NoteW] !==
              due_r.player_mode) begin
            $display("%0t: player_mode mismatch: expected %0d, actual %0d", $time,
                     due_r.player_mode,
                     m_axis_tdata[tdts_pkg::NoteW+tdts_pkg::ModeW-1:tdts_pkg::NoteW]);
            fail_cnt++;
          end
        end
      end
      if (hold_req) begin
        stall_left = 60;
        hold_req   = 1'b0;
      end else if (stall_left == 0 && recv_gaps && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 15);
      end
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog
  initial begin
    #4_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
